### rtl/core/rslope_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rslope_pkg: shared types and constants for the regression slope block
// Widths of the running sums, datapath command/status bundles and the
// operand and accumulate selects of the shared multiplier.
// ----------------------------------------------------------------------------
package rslope_pkg;

  localparam int unsigned MAX_LEN_DEF = 4096;

  localparam int CNT_W   = 17;  // number of taken samples, up to 65536
  localparam int SMP_W   = 32;  // Q16.16 sample
  localparam int SX_W    = 32;  // sum of positions
  localparam int SXX_W   = 48;  // sum of squared positions
  localparam int SY_W    = 48;  // sum of samples
  localparam int SXY_W   = 64;  // sum of position times sample
  localparam int SLOPE_W = 48;
  localparam int MUL_W   = 33;  // signed multiplier operand
  localparam int PROD_W  = 2 * MUL_W;
  localparam int NUM_W   = 83;  // numerator and denominator accumulators
  localparam int DEN_W   = 64;  // denominator as used by the divider
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int HALF_SHIFT = 24;  // split of 48-bit sums into two halves
  localparam int WORD_SHIFT = 32;  // split of the 64-bit sum into two words

  localparam logic [CNT_W-1:0]   MIN_POINTS  = CNT_W'(2);
  localparam logic [SLOPE_W-1:0] SAT_POS     = 48'h7FFF_FFFF_FFFF;
  localparam logic [SLOPE_W-1:0] SAT_NEG_MAG = 48'h8000_0000_0000;

  typedef enum logic [3:0] {
    MUL_X_Y,
    MUL_X_X,
    MUL_N_SXY_LO,
    MUL_N_SXY_HI,
    MUL_SX_SY_LO,
    MUL_SX_SY_HI,
    MUL_N_SXX_LO,
    MUL_N_SXX_HI,
    MUL_SX_SX
  } mul_sel_t;

  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_XY,
    ACC_SMP,
    ACC_NUM_ADD_LO,
    ACC_NUM_ADD_HI,
    ACC_NUM_SUB_LO,
    ACC_NUM_SUB_HI,
    ACC_DEN_ADD_LO,
    ACC_DEN_ADD_HI,
    ACC_DEN_SUB
  } acc_op_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     acc_clr;
    logic     div_init;
    logic     div_step;
    logic     out_load;
    logic     out_ok;
    logic     clear_sums;
  } dp_cmd_t;

  typedef struct packed {
    logic take;
    logic last;
    logic no_slope;
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/core/rslope_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rslope_dp: regression slope datapath
// Running sums, one shared 33x33 multiplier with registered product,
// numerator/denominator accumulators, bit-serial divider and result register.
// ----------------------------------------------------------------------------
module rslope_dp #(
  parameter int unsigned MAX_LEN = rslope_pkg::MAX_LEN_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire rslope_pkg::dp_cmd_t              cmd,
  output rslope_pkg::dp_status_t                status,
  input  wire logic signed [rslope_pkg::SMP_W-1:0]   in_sample,
  input  wire                                   in_sample_null,
  input  wire                                   in_last,
  output logic signed [rslope_pkg::SLOPE_W-1:0] out_slope,
  output logic                                  out_slope_valid,
  output logic                                  out_length_overflow
);

  localparam int CntW   = rslope_pkg::CNT_W;
  localparam int SmpW   = rslope_pkg::SMP_W;
  localparam int SxW    = rslope_pkg::SX_W;
  localparam int SxxW   = rslope_pkg::SXX_W;
  localparam int SyW    = rslope_pkg::SY_W;
  localparam int SxyW   = rslope_pkg::SXY_W;
  localparam int SlopeW = rslope_pkg::SLOPE_W;
  localparam int MulW   = rslope_pkg::MUL_W;
  localparam int ProdW  = rslope_pkg::PROD_W;
  localparam int NumW   = rslope_pkg::NUM_W;
  localparam int DenW   = rslope_pkg::DEN_W;
  localparam int HalfSh = rslope_pkg::HALF_SHIFT;
  localparam int WordSh = rslope_pkg::WORD_SHIFT;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LEN);

  // running sums
  logic [CntW-1:0]        count_r;
  logic [SxW-1:0]         sx_r;
  logic [SxxW-1:0]        sxx_r;
  logic [SyW-1:0]         sy_r;
  logic [SxyW-1:0]        sxy_r;
  logic                   ovf_r;

  logic signed [SmpW-1:0] y_r;
  logic signed [ProdW-1:0] prod_r;
  logic signed [NumW-1:0] num_r;
  logic signed [NumW-1:0] den_r;
  logic [NumW-1:0]        quo_r;
  logic [DenW-1:0]        rem_r;
  logic                   neg_r;

  logic signed [SlopeW-1:0] slope_r;
  logic                     slope_ok_r;
  logic                     length_ovf_r;

  logic                   room;
  logic                   drop;
  logic signed [MulW-1:0] mul_a;
  logic signed [MulW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_nxt;
  logic signed [NumW-1:0] prod_ext;
  logic [DenW:0]          div_shift;
  logic [DenW:0]          div_diff;
  logic                   div_fits;
  logic                   pos_over;
  logic                   neg_over;
  logic [SlopeW-1:0]      mag;
  logic [SlopeW-1:0]      slope_calc;

  assign room = count_r < MaxCnt;
  assign drop = !in_sample_null && !room;

  assign status.take     = !in_sample_null && room;
  assign status.last     = in_last;
  assign status.no_slope = (count_r < rslope_pkg::MIN_POINTS) || (den_r == '0);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      rslope_pkg::MUL_X_Y: begin
        mul_a = {{(MulW-CntW){1'b0}}, count_r};
        mul_b = {{(MulW-SmpW){y_r[SmpW-1]}}, y_r};
      end
      rslope_pkg::MUL_X_X: begin
        mul_a = {{(MulW-CntW){1'b0}}, count_r};
        mul_b = {{(MulW-CntW){1'b0}}, count_r};
      end
      rslope_pkg::MUL_N_SXY_LO: begin
        mul_a = {{(MulW-CntW){1'b0}}, count_r};
        mul_b = {{(MulW-WordSh){1'b0}}, sxy_r[WordSh-1:0]};
      end
      rslope_pkg::MUL_N_SXY_HI: begin
        mul_a = {{(MulW-CntW){1'b0}}, count_r};
        mul_b = {{(MulW-(SxyW-WordSh)){sxy_r[SxyW-1]}}, sxy_r[SxyW-1:WordSh]};
      end
      rslope_pkg::MUL_SX_SY_LO: begin
        mul_a = {{(MulW-SxW){1'b0}}, sx_r};
        mul_b = {{(MulW-HalfSh){1'b0}}, sy_r[HalfSh-1:0]};
      end
      rslope_pkg::MUL_SX_SY_HI: begin
        mul_a = {{(MulW-SxW){1'b0}}, sx_r};
        mul_b = {{(MulW-(SyW-HalfSh)){sy_r[SyW-1]}}, sy_r[SyW-1:HalfSh]};
      end
      rslope_pkg::MUL_N_SXX_LO: begin
        mul_a = {{(MulW-CntW){1'b0}}, count_r};
        mul_b = {{(MulW-HalfSh){1'b0}}, sxx_r[HalfSh-1:0]};
      end
      rslope_pkg::MUL_N_SXX_HI: begin
        mul_a = {{(MulW-CntW){1'b0}}, count_r};
        mul_b = {{(MulW-(SxxW-HalfSh)){1'b0}}, sxx_r[SxxW-1:HalfSh]};
      end
      rslope_pkg::MUL_SX_SX: begin
        mul_a = {{(MulW-SxW){1'b0}}, sx_r};
        mul_b = {{(MulW-SxW){1'b0}}, sx_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign prod_ext = {{(NumW-ProdW){prod_r[ProdW-1]}}, prod_r};

  // restoring divider step: remainder always stays below the denominator
  assign div_shift = {rem_r, quo_r[NumW-1]};
  assign div_diff  = div_shift - {1'b0, den_r[DenW-1:0]};
  assign div_fits  = div_shift >= {1'b0, den_r[DenW-1:0]};

  // saturate the quotient magnitude to the 48-bit signed range
  assign pos_over   = quo_r > {{(NumW-SlopeW){1'b0}}, rslope_pkg::SAT_POS};
  assign neg_over   = quo_r > {{(NumW-SlopeW){1'b0}}, rslope_pkg::SAT_NEG_MAG};
  assign mag        = neg_r ? (neg_over ? rslope_pkg::SAT_NEG_MAG : quo_r[SlopeW-1:0])
                            : (pos_over ? rslope_pkg::SAT_POS : quo_r[SlopeW-1:0]);
  assign slope_calc = neg_r ? (~mag + SlopeW'(1)) : mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sx_r    <= '0;
      sxx_r   <= '0;
      sy_r    <= '0;
      sxy_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.clear_sums) begin
      count_r <= '0;
      sx_r    <= '0;
      sxx_r   <= '0;
      sy_r    <= '0;
      sxy_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.load && drop) begin
        ovf_r <= 1'b1;
      end
      if (cmd.acc_op == rslope_pkg::ACC_XY) begin
        sxy_r <= sxy_r + prod_r[SxyW-1:0];
      end
      if (cmd.acc_op == rslope_pkg::ACC_SMP) begin
        sxx_r   <= sxx_r + prod_r[SxxW-1:0];
        sx_r    <= sx_r + {{(SxW-CntW){1'b0}}, count_r};
        sy_r    <= sy_r + {{(SyW-SmpW){y_r[SmpW-1]}}, y_r};
        count_r <= count_r + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y_r <= in_sample;
    end
    prod_r <= prod_nxt;

    if (cmd.acc_clr) begin
      num_r <= '0;
      den_r <= '0;
    end else begin
      unique case (cmd.acc_op)
        rslope_pkg::ACC_NUM_ADD_LO: num_r <= num_r + prod_ext;
        rslope_pkg::ACC_NUM_ADD_HI: num_r <= num_r + (prod_ext <<< WordSh);
        rslope_pkg::ACC_NUM_SUB_LO: num_r <= num_r - prod_ext;
        rslope_pkg::ACC_NUM_SUB_HI: num_r <= num_r - (prod_ext <<< HalfSh);
        rslope_pkg::ACC_DEN_ADD_LO: den_r <= den_r + prod_ext;
        rslope_pkg::ACC_DEN_ADD_HI: den_r <= den_r + (prod_ext <<< HalfSh);
        rslope_pkg::ACC_DEN_SUB:    den_r <= den_r - prod_ext;
        default: ;
      endcase
    end

    if (cmd.div_init) begin
      neg_r <= num_r[NumW-1];
      quo_r <= num_r[NumW-1] ? unsigned'(-num_r) : unsigned'(num_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_fits ? div_diff[DenW-1:0] : div_shift[DenW-1:0];
      quo_r <= {quo_r[NumW-2:0], div_fits};
    end

    if (cmd.out_load) begin
      slope_r      <= cmd.out_ok ? signed'(slope_calc) : '0;
      slope_ok_r   <= cmd.out_ok;
      length_ovf_r <= ovf_r;
    end
  end

  assign out_slope           = slope_r;
  assign out_slope_valid     = slope_ok_r;
  assign out_length_overflow = length_ovf_r;

endmodule
`default_nettype wire

### rtl/core/rslope_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rslope_ctrl: regression slope sequencer
// Walks the per-sample accumulate steps, the numerator/denominator build,
// the divider iterations and the result handoff; owns both handshakes.
// ----------------------------------------------------------------------------
module rslope_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire                      out_ready,
  output rslope_pkg::dp_cmd_t      cmd,
  input  wire rslope_pkg::dp_status_t status
);

  localparam int CntW = rslope_pkg::DIV_CNT_W;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_XY,
    S_ACC_XY,
    S_ACC_SMP,
    S_N_LO,
    S_N_HI,
    S_M_LO,
    S_M_HI,
    S_D_LO,
    S_D_HI,
    S_D_SQ,
    S_D_END,
    S_CHECK,
    S_DIV,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic            last_r, last_nxt;
  logic            bad_r, bad_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    bad_nxt       = bad_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mul_sel   = rslope_pkg::MUL_X_Y;
    cmd.acc_op    = rslope_pkg::ACC_NONE;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          last_nxt = status.last;
          if (status.take) begin
            state_nxt = S_MUL_XY;
          end else if (status.last) begin
            state_nxt = S_N_LO;
          end
        end
      end
      S_MUL_XY: begin
        cmd.mul_sel = rslope_pkg::MUL_X_Y;
        state_nxt   = S_ACC_XY;
      end
      S_ACC_XY: begin
        cmd.acc_op  = rslope_pkg::ACC_XY;
        cmd.mul_sel = rslope_pkg::MUL_X_X;
        state_nxt   = S_ACC_SMP;
      end
      S_ACC_SMP: begin
        cmd.acc_op = rslope_pkg::ACC_SMP;
        state_nxt  = last_r ? S_N_LO : S_IDLE;
      end
      // numerator: n*Sxy - Sx*Sy, denominator: n*Sxx - Sx*Sx, in partial products
      S_N_LO: begin
        cmd.acc_clr = 1'b1;
        cmd.mul_sel = rslope_pkg::MUL_N_SXY_LO;
        state_nxt   = S_N_HI;
      end
      S_N_HI: begin
        cmd.acc_op  = rslope_pkg::ACC_NUM_ADD_LO;
        cmd.mul_sel = rslope_pkg::MUL_N_SXY_HI;
        state_nxt   = S_M_LO;
      end
      S_M_LO: begin
        cmd.acc_op  = rslope_pkg::ACC_NUM_ADD_HI;
        cmd.mul_sel = rslope_pkg::MUL_SX_SY_LO;
        state_nxt   = S_M_HI;
      end
      S_M_HI: begin
        cmd.acc_op  = rslope_pkg::ACC_NUM_SUB_LO;
        cmd.mul_sel = rslope_pkg::MUL_SX_SY_HI;
        state_nxt   = S_D_LO;
      end
      S_D_LO: begin
        cmd.acc_op  = rslope_pkg::ACC_NUM_SUB_HI;
        cmd.mul_sel = rslope_pkg::MUL_N_SXX_LO;
        state_nxt   = S_D_HI;
      end
      S_D_HI: begin
        cmd.acc_op  = rslope_pkg::ACC_DEN_ADD_LO;
        cmd.mul_sel = rslope_pkg::MUL_N_SXX_HI;
        state_nxt   = S_D_SQ;
      end
      S_D_SQ: begin
        cmd.acc_op  = rslope_pkg::ACC_DEN_ADD_HI;
        cmd.mul_sel = rslope_pkg::MUL_SX_SX;
        state_nxt   = S_D_END;
      end
      S_D_END: begin
        cmd.acc_op = rslope_pkg::ACC_DEN_SUB;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        bad_nxt = status.no_slope;
        if (status.no_slope) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = CntW'(rslope_pkg::NUM_W);
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load   = 1'b1;
          cmd.out_ok     = !bad_r;
          cmd.clear_sums = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      bad_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      bad_r       <= bad_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/regression_slope_of_series.sv
`default_nettype none
// ----------------------------------------------------------------------------
// regression_slope_of_series: least-squares slope of a Q16.16 series
// Accumulates n, Sx, Sxx, Sy, Sxy over valid samples and on the last
// transaction of a series emits (n*Sxy - Sx*Sy) / (n*Sxx - Sx^2) in Q32.16.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   sample, sample_null, last
//   out_      output     out_valid / out_ready slope, slope_valid, length_overflow
//
// A null or dropped sample is handled in the idle state alone; a taken sample
// then steps through MUL_XY, ACC_XY and ACC_SMP, using the shared 33x33
// multiplier for x*y and x*x. A last sample adds the partial products, a check
// state, the bit-serial divider iterations and the load of the output register.
// Synchronous active-low reset clears all sums. A result waiting on out_ready
// stalls only the next result; new samples are taken meanwhile.
// ----------------------------------------------------------------------------
module regression_slope_of_series #(
  parameter int unsigned MAX_LEN = rslope_pkg::MAX_LEN_DEF
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        in_valid,
  output logic                                       in_ready,
  input  wire logic signed [rslope_pkg::SMP_W-1:0]   in_sample,
  input  wire                                        in_sample_null,
  input  wire                                        in_last,
  output logic                                       out_valid,
  input  wire                                        out_ready,
  output logic signed [rslope_pkg::SLOPE_W-1:0]      out_slope,
  output logic                                       out_slope_valid,
  output logic                                       out_length_overflow
);

  rslope_pkg::dp_cmd_t    cmd;
  rslope_pkg::dp_status_t status;

  rslope_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  rslope_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_sample           (in_sample),
    .in_sample_null      (in_sample_null),
    .in_last             (in_last),
    .out_slope           (out_slope),
    .out_slope_valid     (out_slope_valid),
    .out_length_overflow (out_length_overflow)
  );

endmodule
`default_nettype wire

### test/tb_regression_slope_of_series.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_regression_slope_of_series: self-checking bench for the slope block
// Feeds series of Q16.16 samples with null and last marks, predicts the
// least-squares slope, validity and length overflow of every series, and
// compares each result transaction in order. Both channels idle and stall
// at random, with stretches of full rate.
// ----------------------------------------------------------------------------
module tb_regression_slope_of_series;

  localparam int unsigned MAX_LEN       = rslope_pkg::MAX_LEN_DEF;
  localparam int unsigned RANDOM_ITEMS  = 1700;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 150;

  localparam int CNT_W   = rslope_pkg::CNT_W;
  localparam int SMP_W   = rslope_pkg::SMP_W;
  localparam int SX_W    = rslope_pkg::SX_W;
  localparam int SXX_W   = rslope_pkg::SXX_W;
  localparam int SY_W    = rslope_pkg::SY_W;
  localparam int SXY_W   = rslope_pkg::SXY_W;
  localparam int SLOPE_W = rslope_pkg::SLOPE_W;
  localparam logic [CNT_W-1:0]   MIN_POINTS  = rslope_pkg::MIN_POINTS;
  localparam logic [SLOPE_W-1:0] SAT_POS     = rslope_pkg::SAT_POS;
  localparam logic [SLOPE_W-1:0] SAT_NEG_MAG = rslope_pkg::SAT_NEG_MAG;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    is_null;
    logic                    last;
  } sample_txn_t;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic               slope_ok;
    logic               len_ovf;
  } slope_txn_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [SMP_W-1:0]   in_sample = '0;
  logic                      in_sample_null = 1'b0;
  logic                      in_last = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SLOPE_W-1:0] out_slope;
  logic                      out_slope_valid;
  logic                      out_length_overflow;

  sample_txn_t pending_samples[$];
  slope_txn_t  expected_slopes[$];

  // running sums of the series in progress
  logic [CNT_W-1:0]        pos_count;
  logic [SX_W-1:0]         pos_sum;
  logic [SXX_W-1:0]        pos_sq_sum;
  logic signed [SY_W-1:0]  val_sum;
  logic signed [SXY_W-1:0] pos_val_sum;
  logic                    len_dropped;

  int unsigned queued_count = 0;
  int unsigned fed_count = 0;
  int unsigned result_count = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  sample_txn_t nxt;
  slope_txn_t  want;

  regression_slope_of_series #(.MAX_LEN(MAX_LEN)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .in_sample_null     (in_sample_null),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_slope          (out_slope),
    .out_slope_valid    (out_slope_valid),
    .out_length_overflow(out_length_overflow)
  );

  always #4 clk = ~clk;

  function automatic int unsigned idle_len(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_series();
    pos_count   = '0;
    pos_sum     = '0;
    pos_sq_sum  = '0;
    val_sum     = '0;
    pos_val_sum = '0;
    len_dropped = 1'b0;
  endtask

  // Fold one accepted transaction into the sums; on the last one, form the slope.
  task automatic take_sample(input logic signed [SMP_W-1:0] y, input logic is_null,
                             input logic is_last);
    logic signed [127:0] num, n_w, sx_w, sy_w, sxy_w;
    logic [127:0]        mag, quo;
    logic [63:0]         den;
    slope_txn_t          res;
    if (!is_null) begin
      if (pos_count >= MAX_LEN) begin
        len_dropped = 1'b1;
      end else begin
        pos_sum     = pos_sum + SX_W'(pos_count);
        pos_sq_sum  = pos_sq_sum + SXX_W'(pos_count) * SXX_W'(pos_count);
        val_sum     = val_sum + {{(SY_W-SMP_W){y[SMP_W-1]}}, y};
        pos_val_sum = pos_val_sum + $signed({47'd0, pos_count}) * y;
        pos_count   = pos_count + 1'b1;
      end
    end
    if (is_last) begin
      res.slope    = '0;
      res.slope_ok = 1'b0;
      res.len_ovf  = len_dropped;
      den = 64'(pos_count) * 64'(pos_sq_sum) - 64'(pos_sum) * 64'(pos_sum);
      if (pos_count >= MIN_POINTS && den != 64'd0) begin
        n_w   = {111'd0, pos_count};
        sx_w  = {96'd0, pos_sum};
        sy_w  = {{80{val_sum[SY_W-1]}}, val_sum};
        sxy_w = {{64{pos_val_sum[SXY_W-1]}}, pos_val_sum};
        num   = n_w * sxy_w - sx_w * sy_w;
        mag   = num[127] ? -num : num;
        quo   = mag / {64'd0, den};
        // truncate toward zero, then clamp to the 48-bit range
        if (num[127]) begin
          if (quo > {80'd0, SAT_NEG_MAG}) quo = {80'd0, SAT_NEG_MAG};
          res.slope = 48'd0 - quo[SLOPE_W-1:0];
        end else begin
          if (quo > {80'd0, SAT_POS}) quo = {80'd0, SAT_POS};
          res.slope = quo[SLOPE_W-1:0];
        end
        res.slope_ok = 1'b1;
      end
      expected_slopes.insert(expected_slopes.size(), res);
      clear_series();
    end
  endtask

  task automatic push_item(input logic signed [SMP_W-1:0] y, input logic is_null,
                           input logic is_last);
    sample_txn_t t;
    t.sample  = y;
    t.is_null = is_null;
    t.last    = is_last;
    pending_samples.insert(pending_samples.size(), t);
    queued_count++;
  endtask

  // One series of len transactions; the final one carries last.
  task automatic push_series(input int unsigned len, input int unsigned null_pct);
    int unsigned shape;
    int          base, ramp, v;
    shape = $urandom_range(0, 3);
    base  = $urandom;
    ramp  = $signed($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
    for (int unsigned i = 0; i < len; i++) begin
      case (shape)
        0: v = $urandom;
        1: v = base + int'(i) * ramp + $signed($urandom_range(0, 511)) - 256;
        2: v = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: v = $signed($urandom_range(0, 511)) - 256;
      endcase
      push_item(v, $urandom_range(0, 99) < null_pct, i == len - 1);
    end
  endtask

  initial begin
    int unsigned random_items, len, r;
    int unsigned null_choice[6];
    null_choice = '{0, 0, 10, 30, 60, 100};

    // empty series closed by a null, and a single sample
    push_item(32'sh1234_5678, 1'b1, 1'b1);
    push_item(32'sh0005_0000, 1'b0, 1'b1);
    // steepest rise and fall between the field extremes
    push_item(32'sh8000_0000, 1'b0, 1'b0);
    push_item(32'sh7FFF_FFFF, 1'b0, 1'b1);
    push_item(32'sh7FFF_FFFF, 1'b0, 1'b0);
    push_item(32'sh8000_0000, 1'b0, 1'b1);
    // null last transaction after valid samples
    push_item(32'sh0000_0001, 1'b0, 1'b0);
    push_item(32'sh0000_007B, 1'b1, 1'b0);
    push_item(32'sh0000_0003, 1'b0, 1'b0);
    push_item(32'shFFFF_FFFF, 1'b1, 1'b1);
    // nulls then one valid last: too few points
    push_item(32'sh7FFF_FFFF, 1'b1, 1'b0);
    push_item(32'sh8000_0000, 1'b1, 1'b0);
    push_item(32'sh0000_0007, 1'b0, 1'b1);
    // flat series, then a unit ramp
    for (int i = 0; i < 4; i++) push_item(-32'sd1, 1'b0, i == 3);
    for (int i = 0; i < 4; i++) push_item(i * 32'sh0001_0000, 1'b0, i == 3);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 16);
      else if (r < 97) len = $urandom_range(17, 80);
      else len = $urandom_range(81, 400);
      push_series(len, null_choice[$urandom_range(0, 5)]);
      random_items += len;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (fed_count != queued_count) @(posedge clk);
    while (expected_slopes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Driver: hold a transaction until accepted, then idle for a drawn gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
      clear_series();
    end else begin
      if (in_valid && in_ready) begin
        take_sample(in_sample, in_sample_null, in_last);
        fed_count++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0 || pending_samples.size() == 0) begin
          if (in_gap != 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          nxt = pending_samples.pop_front();
          in_valid       <= 1'b1;
          in_sample      <= nxt.sample;
          in_sample_null <= nxt.is_null;
          in_last        <= nxt.last;
          in_gap = idle_len((fed_count % 450) >= 300);
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_slopes.size() == 0) begin
          $error("result with no series pending: slope %0d", out_slope);
          fail_count++;
        end else begin
          want = expected_slopes.pop_front();
          if (out_slope !== want.slope) begin
            $error("slope: expected %0d, actual %0d", $signed(want.slope), out_slope);
            fail_count++;
          end
          if (out_slope_valid !== want.slope_ok) begin
            $error("slope_valid: expected %0b, actual %0b", want.slope_ok,
                   out_slope_valid);
            fail_count++;
          end
          if (out_length_overflow !== want.len_ovf) begin
            $error("length_overflow: expected %0b, actual %0b", want.len_ovf,
                   out_length_overflow);
            fail_count++;
          end
        end
        result_count++;
      end
      if (out_hold != 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_hold = idle_len((result_count % 60) >= 45);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
